// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define IMH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define IMH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/imh_pkg.sv =====
// constants and codes for the indexed min-heap core
// no dependencies
`default_nettype none

package imh_pkg;
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int KEY_W    = 32;

   localparam logic [1:0] ACT_SET_KEY = 2'd0;
   localparam logic [1:0] ACT_POP     = 2'd1;
   localparam logic [1:0] ACT_REMOVE  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_BAD_SLOT = 2'd2;
endpackage

`default_nettype wire

// ===== hw/rtl/indexed_min_heap_core.sv =====
// indexed binary min-heap with decrease-key, single shared key comparator
// depends on imh_pkg and imh_ram
//
// usage
//  - request channel req_*: action, item, key, slot; one transaction per action
//  - response channel rsp_*: exactly one transaction per request, giving status,
//    removed item, root item and key, entry count and an empty flag
//  - req_ready is high only while the core is idle; one action is in flight
//  - set key: map lookup, then a parent read and compare per level climbed,
//    then the result; pop / remove: take-out and last-entry fetch, then the
//    climb and a descent that reads both children per level, bounded by the
//    tree depth and the one read port of each memory
//  - after reset a clearing pass marks every item absent in the
//    item-to-slot map; req_ready stays low during it
//  - the response is held in registers; while rsp_ready is low the core
//    waits and takes no new request
//  - keys compare as signed two's complement, ties keep the lower entry
`default_nettype none

module indexed_min_heap_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_action,
   input  wire logic [imh_pkg::ADDR_W-1:0]  req_item,
   input  wire logic signed [imh_pkg::KEY_W-1:0] req_key,
   input  wire logic [imh_pkg::ADDR_W-1:0]  req_slot,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [imh_pkg::ADDR_W-1:0]       rsp_removed_item,
   output logic [imh_pkg::ADDR_W-1:0]       rsp_min_item,
   output logic signed [imh_pkg::KEY_W-1:0] rsp_min_key,
   output logic [imh_pkg::CNT_W-1:0]        rsp_count,
   output logic                             rsp_empty_res
);
   import imh_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_MAP, S_UP, S_UP_P, S_UP_K, S_TAKE, S_TK_G, S_TK_L,
      S_TK_K, S_DOWN, S_DN_L, S_DN_R, S_DN_RK, S_DN_CMP, S_FIN, S_FR, S_FK,
      S_OUT
   } state_type;

   state_type state_ff;

   logic [CNT_W-1:0]        clr_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [ADDR_W-1:0]       pos_ff;
   logic [ADDR_W-1:0]       it_ff;
   logic signed [KEY_W-1:0] k_ff;
   logic [ADDR_W-1:0]       p_ff;
   logic [CNT_W-1:0]        c_ff;
   logic [ADDR_W-1:0]       litem_ff;
   logic [ADDR_W-1:0]       ritem_ff;
   logic signed [KEY_W-1:0] lkey_ff;
   logic [ADDR_W-1:0]       citem_ff;
   logic signed [KEY_W-1:0] ckey_ff;
   logic                    take_ff;
   logic [ADDR_W-1:0]       root_ff;

   // memory ports
   logic                    heap_we, map_we, key_we;
   logic [ADDR_W-1:0]       heap_wa, heap_ra, map_wa, map_ra, key_wa, key_ra;
   logic [ADDR_W-1:0]       heap_wd, heap_rd;
   logic [CNT_W-1:0]        map_wd, map_rd;
   logic [KEY_W-1:0]        key_wd, key_rd;

   // shared comparator
   logic signed [KEY_W-1:0] cmp_a, cmp_b;
   logic                    cmp_lt;

   logic [CNT_W-1:0]        child_in;
   logic                    has_right;
   logic [ADDR_W-1:0]       par;

   assign cmp_lt    = cmp_a < cmp_b;
   assign child_in  = {pos_ff, 1'b1};
   assign has_right = ({1'b0, c_ff} + (CNT_W+1)'(1)) < {1'b0, cnt_ff};
   assign par       = (pos_ff - ADDR_W'(1)) >> 1;
   assign req_ready = (state_ff == S_IDLE);

   imh_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_heap (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
      .rd_addr(heap_ra), .rd_data(heap_rd));

   imh_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_addr(map_ra), .rd_data(map_rd));

   imh_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(key_ra), .rd_data(key_rd));

   // memory addressing per sequencer step
   always_comb begin
      heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = '0;
      map_we  = 1'b0; map_wa  = '0; map_wd  = '0; map_ra  = '0;
      key_we  = 1'b0; key_wa  = '0; key_wd  = '0; key_ra  = '0;
      cmp_a   = k_ff; cmp_b   = k_ff;
      unique case (state_ff)
         S_CLEAR: begin
            map_we = 1'b1;
            map_wa = clr_ff[ADDR_W-1:0];
         end
         S_IDLE: begin
            key_wa = req_item;
            key_wd = req_key;
            map_ra = req_item;
            key_we = req_valid && (req_action == ACT_SET_KEY);
         end
         S_UP: begin
            heap_ra = par;
            if (pos_ff == '0) begin
               // reached the root, place the moving item
               heap_we = 1'b1; heap_wa = pos_ff; heap_wd = it_ff;
               map_we  = 1'b1; map_wa  = it_ff;  map_wd  = {1'b1, pos_ff};
            end
         end
         S_UP_P: key_ra = heap_rd;
         S_UP_K: begin
            cmp_a = k_ff; cmp_b = key_rd;
            heap_we = 1'b1; heap_wa = pos_ff;
            map_we  = 1'b1;
            if (cmp_lt) begin
               // parent moves down a level
               heap_wd = p_ff; map_wa = p_ff; map_wd = {1'b1, pos_ff};
            end else begin
               heap_wd = it_ff; map_wa = it_ff; map_wd = {1'b1, pos_ff};
            end
         end
         S_TAKE: heap_ra = pos_ff;
         S_TK_G: begin
            // taken-out item marked absent, last entry fetched
            map_we  = 1'b1; map_wa = heap_rd; map_wd = '0;
            heap_ra = ADDR_W'(cnt_ff - CNT_W'(1));
         end
         S_TK_L: key_ra = heap_rd;
         S_DOWN: begin
            heap_ra = child_in[ADDR_W-1:0];
            if (child_in >= cnt_ff) begin
               heap_we = 1'b1; heap_wa = pos_ff; heap_wd = it_ff;
               map_we  = 1'b1; map_wa  = it_ff;  map_wd  = {1'b1, pos_ff};
            end
         end
         S_DN_L: begin
            key_ra  = heap_rd;
            heap_ra = ADDR_W'(c_ff + CNT_W'(1));
         end
         S_DN_R: key_ra = heap_rd;
         S_DN_RK: begin
            cmp_a = key_rd; cmp_b = lkey_ff;
         end
         S_DN_CMP: begin
            cmp_a = ckey_ff; cmp_b = k_ff;
            heap_we = 1'b1; heap_wa = pos_ff;
            map_we  = 1'b1;
            if (cmp_lt) begin
               // smaller child moves up
               heap_wd = citem_ff; map_wa = citem_ff; map_wd = {1'b1, pos_ff};
            end else begin
               heap_wd = it_ff; map_wa = it_ff; map_wd = {1'b1, pos_ff};
            end
         end
         S_FIN: heap_ra = '0;
         S_FR:  key_ra = heap_rd;
         default: begin
         end
      endcase
   end

   // sequencer and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         cnt_ff    <= '0;
         rsp_valid <= 1'b0;
         take_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CNT_W'(1);
               if (clr_ff == CNT_W'(CAPACITY - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  rsp_status       <= ST_OK;
                  rsp_removed_item <= '0;
                  it_ff            <= req_item;
                  k_ff             <= req_key;
                  take_ff          <= 1'b0;
                  priority if (req_action == ACT_SET_KEY) begin
                     state_ff <= S_MAP;
                  end else if (req_action == ACT_POP) begin
                     pos_ff <= '0;
                     if (cnt_ff == '0) begin
                        rsp_status <= ST_EMPTY;
                        state_ff   <= S_FIN;
                     end else begin
                        state_ff <= S_TAKE;
                     end
                  end else if (req_action == ACT_REMOVE) begin
                     pos_ff <= req_slot;
                     if ({1'b0, req_slot} >= cnt_ff) begin
                        rsp_status <= ST_BAD_SLOT;
                        state_ff   <= S_FIN;
                     end else begin
                        state_ff <= S_TAKE;
                     end
                  end else begin
                     state_ff <= S_FIN;
                  end
               end
            end
            S_MAP: begin
               if (map_rd[CNT_W-1]) begin
                  pos_ff   <= map_rd[ADDR_W-1:0];
                  state_ff <= S_UP;
               end else if (cnt_ff < CNT_W'(CAPACITY)) begin
                  pos_ff   <= cnt_ff[ADDR_W-1:0];
                  cnt_ff   <= cnt_ff + CNT_W'(1);
                  state_ff <= S_UP;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_UP: begin
               if (pos_ff == '0) begin
                  state_ff <= take_ff ? S_DOWN : S_FIN;
               end else begin
                  state_ff <= S_UP_P;
               end
            end
            S_UP_P: begin
               p_ff     <= heap_rd;
               state_ff <= S_UP_K;
            end
            S_UP_K: begin
               if (cmp_lt) begin
                  pos_ff   <= par;
                  state_ff <= S_UP;
               end else begin
                  state_ff <= take_ff ? S_DOWN : S_FIN;
               end
            end
            S_TAKE: state_ff <= S_TK_G;
            S_TK_G: begin
               rsp_removed_item <= heap_rd;
               cnt_ff           <= cnt_ff - CNT_W'(1);
               // last entry taken: nothing to move
               if ({1'b0, pos_ff} == cnt_ff - CNT_W'(1)) begin
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_TK_L;
               end
            end
            S_TK_L: begin
               it_ff    <= heap_rd;
               state_ff <= S_TK_K;
            end
            S_TK_K: begin
               k_ff     <= key_rd;
               take_ff  <= 1'b1;
               state_ff <= S_UP;
            end
            S_DOWN: begin
               c_ff     <= child_in;
               state_ff <= (child_in >= cnt_ff) ? S_FIN : S_DN_L;
            end
            S_DN_L: begin
               litem_ff <= heap_rd;
               state_ff <= S_DN_R;
            end
            S_DN_R: begin
               lkey_ff  <= key_rd;
               ritem_ff <= heap_rd;
               citem_ff <= litem_ff;
               ckey_ff  <= key_rd;
               state_ff <= has_right ? S_DN_RK : S_DN_CMP;
            end
            S_DN_RK: begin
               // right child only if strictly smaller
               if (cmp_lt) begin
                  citem_ff <= ritem_ff;
                  ckey_ff  <= key_rd;
                  c_ff     <= c_ff + CNT_W'(1);
               end
               state_ff <= S_DN_CMP;
            end
            S_DN_CMP: begin
               if (cmp_lt) begin
                  pos_ff   <= c_ff[ADDR_W-1:0];
                  state_ff <= S_DOWN;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               rsp_count     <= cnt_ff;
               rsp_empty_res <= (cnt_ff == '0);
               if (cnt_ff == '0) begin
                  rsp_min_item <= '0;
                  rsp_min_key  <= '0;
                  rsp_valid    <= 1'b1;
                  state_ff     <= S_OUT;
               end else begin
                  state_ff <= S_FR;
               end
            end
            S_FR: begin
               root_ff  <= heap_rd;
               state_ff <= S_FK;
            end
            S_FK: begin
               rsp_min_item <= root_ff;
               rsp_min_key  <= key_rd;
               rsp_valid    <= 1'b1;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

`default_nettype wire

// ===== hw/rtl/imh_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module imh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

`default_nettype wire

// ===== hw/rtl/imh_checker.sv =====
// port-level checks for the indexed min-heap core, bound into the core module
// depends on imh_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module imh_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [imh_pkg::ADDR_W-1:0]  rsp_min_item,
   input wire logic [imh_pkg::CNT_W-1:0]   rsp_count,
   input wire logic                        rsp_empty_res
);
   import imh_pkg::*;

   `IMH_ASSERT_NOW(a_one_in_flight, clock, reset, rsp_valid, !req_ready)
   `IMH_ASSERT_NOW(a_empty_flag, clock, reset, rsp_valid, rsp_empty_res == (rsp_count == '0))
   `IMH_ASSERT_NOW(a_empty_root, clock, reset, rsp_valid && rsp_empty_res, rsp_min_item == '0)
   `IMH_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `IMH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count))
endmodule

bind indexed_min_heap_core imh_checker u_imh_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_min_item(rsp_min_item),
   .rsp_count(rsp_count), .rsp_empty_res(rsp_empty_res));

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for indexed_min_heap_core: directed and random heap actions
// depends on imh_pkg and the core rtl; holds its own heap predictor and a response scoreboard
`timescale 1ns / 100ps

module tb_top;
   import imh_pkg::*;

   // action code the core ignores, answered with ok and no change
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] item;
      logic [KEY_W-1:0]  key;
      logic [ADDR_W-1:0] slot;
   } heap_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] removed_item;
      logic [ADDR_W-1:0] min_item;
      logic [KEY_W-1:0]  min_key;
      logic [CNT_W-1:0]  count;
      logic              empty_res;
   } heap_rsp_type;

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   logic [1:0] req_action;
   logic [ADDR_W-1:0] req_item, req_slot;
   logic signed [KEY_W-1:0] req_key;
   logic rsp_valid, rsp_ready;
   logic [1:0] rsp_status;
   logic [ADDR_W-1:0] rsp_removed_item, rsp_min_item;
   logic signed [KEY_W-1:0] rsp_min_key;
   logic [CNT_W-1:0] rsp_count;
   logic rsp_empty_res;

   indexed_min_heap_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_item(req_item), .req_key(req_key), .req_slot(req_slot),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_removed_item(rsp_removed_item),
      .rsp_min_item(rsp_min_item), .rsp_min_key(rsp_min_key),
      .rsp_count(rsp_count), .rsp_empty_res(rsp_empty_res)
   );

   // stimulus waiting for the driver and responses waiting for the core
   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   int unsigned mismatches = 0;
   int unsigned accepted_reqs = 0;
   int unsigned checked_rsps = 0;
   int unsigned pops_done = 0;
   int unsigned removes_done = 0;
   int unsigned error_rsps = 0;

   // shadow of the heap: slot contents, item keys, item positions, presence
   logic [ADDR_W-1:0]       shadow_slots [CAPACITY];
   logic signed [KEY_W-1:0] shadow_keys  [CAPACITY];
   int unsigned             shadow_pos   [CAPACITY];
   bit                      shadow_here  [CAPACITY];
   int unsigned             shadow_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void place(int unsigned pos, logic [ADDR_W-1:0] it);
      shadow_slots[pos] = it;
      shadow_pos[it] = pos;
   endfunction

   function automatic int unsigned climb(int unsigned pos, logic [ADDR_W-1:0] it);
      int unsigned par;
      logic [ADDR_W-1:0] up;
      while (pos > 0) begin
         par = (pos - 1) / 2;
         up = shadow_slots[par];
         if (shadow_keys[it] >= shadow_keys[up]) break;
         place(pos, up);
         pos = par;
      end
      place(pos, it);
      return pos;
   endfunction

   function automatic void descend(int unsigned pos, logic [ADDR_W-1:0] it);
      int unsigned c;
      forever begin
         c = 2 * pos + 1;
         if (c >= shadow_count) break;
         // left child wins ties
         if (c + 1 < shadow_count &&
             shadow_keys[shadow_slots[c]] > shadow_keys[shadow_slots[c + 1]]) c++;
         if (shadow_keys[it] <= shadow_keys[shadow_slots[c]]) break;
         place(pos, shadow_slots[c]);
         pos = c;
      end
      place(pos, it);
   endfunction

   function automatic logic [ADDR_W-1:0] extract_at(int unsigned pos);
      logic [ADDR_W-1:0] gone, last;
      int unsigned p;
      gone = shadow_slots[pos];
      shadow_count--;
      shadow_here[gone] = 1'b0;
      if (pos != shadow_count) begin
         last = shadow_slots[shadow_count];
         p = climb(pos, last);
         descend(p, last);
      end
      return gone;
   endfunction

   // applies one action to the shadow heap and returns the response it implies
   function automatic heap_rsp_type apply_action(heap_req_type r);
      heap_rsp_type o;
      int unsigned pos;
      o = '0;
      o.status = ST_OK;
      case (r.action)
         ACT_SET_KEY: begin
            shadow_keys[r.item] = r.key;
            if (shadow_here[r.item]) begin
               // raised key stays put, only climbs are done
               void'(climb(shadow_pos[r.item], r.item));
            end else if (shadow_count < CAPACITY) begin
               pos = shadow_count;
               shadow_count++;
               shadow_here[r.item] = 1'b1;
               void'(climb(pos, r.item));
            end
         end
         ACT_POP: begin
            if (shadow_count == 0) o.status = ST_EMPTY;
            else o.removed_item = extract_at(0);
         end
         ACT_REMOVE: begin
            if (r.slot >= shadow_count) o.status = ST_BAD_SLOT;
            else o.removed_item = extract_at(r.slot);
         end
         default: ;
      endcase
      if (shadow_count > 0) begin
         o.min_item = shadow_slots[0];
         o.min_key = shadow_keys[shadow_slots[0]];
      end
      o.empty_res = (shadow_count == 0);
      o.count = CNT_W'(shadow_count);
      return o;
   endfunction

   function automatic void add_req(logic [1:0] act, int unsigned it, logic [KEY_W-1:0] k,
                                   int unsigned sl);
      heap_req_type r;
      r.action = act;
      r.item = ADDR_W'(it);
      r.key = k;
      r.slot = ADDR_W'(sl);
      pending_reqs.push_back(r);
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   // driver: bursts of random length separated by random gaps
   int unsigned burst_left = 4;
   int unsigned gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_action <= ACT_SET_KEY;
         req_item <= '0;
         req_key <= '0;
         req_slot <= '0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            heap_req_type r;
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_action <= r.action;
            req_item <= r.item;
            req_key <= r.key;
            req_slot <= r.slot;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: own stall pattern, plus one long hold-off to back the core up
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_reqs == 600) begin
         hold_done = 1'b1;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         // quiet stretches between phases of frequent stalls
         if ((accepted_reqs / 200) % 2 == 1 && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 12);
      end
   end

   // monitor: predicts on each accepted request, checks each accepted response
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            heap_req_type r;
            heap_rsp_type e;
            r.action = req_action;
            r.item = req_item;
            r.key = req_key;
            r.slot = req_slot;
            e = apply_action(r);
            if (r.action == ACT_POP && e.status == ST_OK) pops_done++;
            if (r.action == ACT_REMOVE && e.status == ST_OK) removes_done++;
            if (e.status != ST_OK) error_rsps++;
            expected_rsps.push_back(e);
            accepted_reqs++;
         end
         if (rsp_valid && rsp_ready) begin
            heap_rsp_type e;
            if (expected_rsps.size() == 0) begin
               $error("response transaction with nothing expected");
               mismatches++;
            end else begin
               e = expected_rsps.pop_front();
               checked_rsps++;
               if (rsp_status !== e.status) begin
                  $error("status expected %0d got %0d", e.status, rsp_status);
                  mismatches++;
               end
               if (rsp_removed_item !== e.removed_item) begin
                  $error("removed_item expected %0d got %0d", e.removed_item,
                         rsp_removed_item);
                  mismatches++;
               end
               if (rsp_min_item !== e.min_item) begin
                  $error("min_item expected %0d got %0d", e.min_item, rsp_min_item);
                  mismatches++;
               end
               if (rsp_min_key !== e.min_key) begin
                  $error("min_key expected %0d got %0d", $signed(e.min_key), rsp_min_key);
                  mismatches++;
               end
               if (rsp_count !== e.count) begin
                  $error("count expected %0d got %0d", e.count, rsp_count);
                  mismatches++;
               end
               if (rsp_empty_res !== e.empty_res) begin
                  $error("empty_res expected %0d got %0d", e.empty_res, rsp_empty_res);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d responses outstanding", expected_rsps.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int unsigned est;
      int unsigned act;
      reset = 1'b1;

      // directed: empty heap errors, extremes, ties, raised key, unused code
      add_req(ACT_POP, 0, 0, 0);
      add_req(ACT_REMOVE, 0, 0, 0);
      add_req(ACT_UNUSED, 1023, 32'hFFFF_FFFF, 1023);
      add_req(ACT_SET_KEY, 1023, 32'h7FFF_FFFF, 0);
      add_req(ACT_SET_KEY, 0, 32'h8000_0000, 0);
      add_req(ACT_SET_KEY, 5, 0, 0);
      add_req(ACT_SET_KEY, 6, 0, 0);
      add_req(ACT_SET_KEY, 7, 0, 0);
      add_req(ACT_SET_KEY, 0, 32'h7FFF_FFFF, 0);
      add_req(ACT_SET_KEY, 1023, 32'h8000_0000, 0);
      add_req(ACT_SET_KEY, 512, 32'hFFFF_FFFF, 0);
      add_req(ACT_REMOVE, 0, 0, 1023);
      add_req(ACT_REMOVE, 0, 0, 6);
      add_req(ACT_REMOVE, 0, 0, 2);
      add_req(ACT_POP, 0, 0, 0);
      add_req(ACT_SET_KEY, 1023, 5, 0);
      add_req(ACT_POP, 0, 0, 0);
      add_req(ACT_POP, 0, 0, 0);
      add_req(ACT_POP, 0, 0, 0);
      add_req(ACT_POP, 0, 0, 0);
      add_req(ACT_POP, 0, 0, 0);
      add_req(ACT_UNUSED, 0, 0, 0);
      est = 0;

      // random: a small item pool keeps the heap busy, set keys outweigh takes
      for (int n = 0; n < 1500; n++) begin
         act = $urandom_range(0, 19);
         if (act < 10) begin
            add_req(ACT_SET_KEY,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 95),
                    rand_key(), $urandom);
            est++;
         end else if (act < 14) begin
            add_req(ACT_POP, $urandom, $urandom, $urandom);
            if (est > 0) est--;
         end else if (act < 19) begin
            add_req(ACT_REMOVE, $urandom, $urandom,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, est + 4));
            if (est > 0) est--;
         end else begin
            add_req(ACT_UNUSED, $urandom, $urandom, $urandom);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0);
      repeat (100) @(posedge clock);

      $display("covered %0d actions: %0d pops, %0d removes, %0d error answers",
               accepted_reqs, pops_done, removes_done, error_rsps);
      $display("%0d responses checked, %0d field mismatches", checked_rsps, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
